@@ hw/rtl/gld_pkg.sv @@
// Shared types and constants of the GIF LZW decoder.
// No dependencies; imported by every module of the block but gld_ram.
package gld_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int QUEUE_DEPTH   = 256;
    localparam int TABLE_SIZE    = 1 << MAX_CODE_BITS;
    localparam int STACK_SIZE    = TABLE_SIZE + 1;
    localparam int SP_W          = $clog2(STACK_SIZE + 1);
    localparam int QA_W          = $clog2(QUEUE_DEPTH);
    localparam int QC_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int CODE_W        = MAX_CODE_BITS;
    localparam int CNT_W         = MAX_CODE_BITS + 1;
    localparam int ACC_W         = 24;
    localparam int HELD_W        = 5;
    localparam int ROOT_W        = 4;
    localparam int MIN_ROOT      = 2;
    localparam int MAX_ROOT      = 8;
    localparam int CQ_DEPTH      = 2;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_PUSH  = 2'd1,
        OP_PULL  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_SYM  = 3'd0,
        ST_OK   = 3'd1,
        ST_NEED = 3'd2,
        ST_END  = 3'd3,
        ST_ERR  = 3'd4,
        ST_OVF  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        PH_FRESH = 2'd0,
        PH_RUN   = 2'd1,
        PH_END   = 2'd2,
        PH_ERR   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] symbol;
        logic [2:0] status;
    } t_out;

    typedef struct packed {
        t_op        kind;
        logic [7:0] data;
    } t_cmd;

endpackage

@@ hw/rtl/gld_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module gld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ hw/rtl/gld_front.sv @@
// Command front end: accepts transfers, classifies them and queues them.
// Depends on gld_pkg.
module gld_front import gld_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_in,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_cmd_pop
);

    localparam int PW = $clog2(CQ_DEPTH);
    localparam int CW = $clog2(CQ_DEPTH + 1);

    t_cmd          r_buf [CQ_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    t_cmd          w_cmd;

    always_comb begin
        w_cmd.data = i_in.data_byte;
        unique case (t_op'(i_in.operation))
            OP_START: w_cmd.kind = OP_START;
            OP_PUSH:  w_cmd.kind = OP_PUSH;
            OP_PULL:  w_cmd.kind = OP_PULL;
            default:  w_cmd.kind = OP_NOP;
        endcase
    end

    assign busy        = (r_cnt == CW'(CQ_DEPTH));
    assign w_push      = start && !busy;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(CQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rp <= (r_rp == PW'(CQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(w_push) - CW'(i_cmd_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= w_cmd;
        end
    end

endmodule

@@ hw/rtl/gld_back.sv @@
// Decode engine: byte queue, code unpacker, dictionary walk and symbol stack.
// Depends on gld_pkg and gld_ram.
module gld_back import gld_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic o_strobe,
    output t_out o_result
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FETCH = 7'b0000010,
        S_QRD   = 7'b0000100,
        S_CODE  = 7'b0001000,
        S_WALK  = 7'b0010000,
        S_WDAT  = 7'b0100000,
        S_POP   = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [ROOT_W-1:0] r_cw, n_cw;
    logic [CNT_W-1:0]  r_limit, n_limit;
    logic [CNT_W-1:0]  r_free, n_free;
    logic [7:0]        r_first, n_first;
    logic [CODE_W-1:0] r_prev, n_prev;
    logic [CODE_W-1:0] r_code, n_code;
    logic [CODE_W-1:0] r_incode, n_incode;
    t_phase            r_phase, n_phase;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [HELD_W-1:0] r_held, n_held;
    logic [7:0]        r_sub, n_sub;
    logic              r_term, n_term;
    logic [QA_W-1:0]   r_head, n_head;
    logic [QA_W-1:0]   r_tail, n_tail;
    logic [QC_W-1:0]   r_count, n_count;
    logic [SP_W-1:0]   r_sp, n_sp;
    logic              r_strobe, n_strobe;
    t_out              r_res, n_res;

    logic              w_q_we;
    logic [7:0]        w_q_rdata;
    logic              w_s_we;
    logic [7:0]        w_s_wdata;
    logic [7:0]        w_s_rdata;
    logic              w_d_we;
    logic [CODE_W-1:0] w_p_rdata;
    logic [7:0]        w_x_rdata;
    logic [CNT_W-1:0]  w_clear;
    logic [CNT_W-1:0]  w_code_x;
    logic [CODE_W-1:0] w_mask;
    logic [ROOT_W-1:0] w_new_root;
    logic [CNT_W-1:0]  w_new_clear;
    logic [CNT_W-1:0]  w_free_inc;

    assign w_clear    = CNT_W'(1) << r_root;
    assign w_code_x   = CNT_W'(r_code);
    assign w_mask     = ~({CODE_W{1'b1}} << r_cw);
    assign w_free_inc = r_free + 1'b1;

    always_comb begin
        if (i_cmd.data < 8'(MIN_ROOT)) begin
            w_new_root = ROOT_W'(MIN_ROOT);
        end else if (i_cmd.data > 8'(MAX_ROOT)) begin
            w_new_root = ROOT_W'(MAX_ROOT);
        end else begin
            w_new_root = i_cmd.data[ROOT_W-1:0];
        end
    end
    assign w_new_clear = CNT_W'(1) << w_new_root;

    gld_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_waddr (r_tail),
        .i_wdata (i_cmd.data),
        .i_raddr (r_head),
        .o_rdata (w_q_rdata)
    );

    gld_ram #(.WIDTH(8), .DEPTH(STACK_SIZE)) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_s_we),
        .i_waddr (r_sp),
        .i_wdata (w_s_wdata),
        .i_raddr (r_sp - 1'b1),
        .o_rdata (w_s_rdata)
    );

    gld_ram #(.WIDTH(CODE_W), .DEPTH(TABLE_SIZE)) u_prefix (
        .i_clk   (i_clk),
        .i_we    (w_d_we),
        .i_waddr (r_free[CODE_W-1:0]),
        .i_wdata (r_prev),
        .i_raddr (r_code),
        .o_rdata (w_p_rdata)
    );

    gld_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_suffix (
        .i_clk   (i_clk),
        .i_we    (w_d_we),
        .i_waddr (r_free[CODE_W-1:0]),
        .i_wdata (r_code[7:0]),
        .i_raddr (r_code),
        .o_rdata (w_x_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_root   = r_root;
        n_cw     = r_cw;
        n_limit  = r_limit;
        n_free   = r_free;
        n_first  = r_first;
        n_prev   = r_prev;
        n_code   = r_code;
        n_incode = r_incode;
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_held   = r_held;
        n_sub    = r_sub;
        n_term   = r_term;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_sp     = r_sp;
        n_strobe = 1'b0;
        n_res    = r_res;
        o_cmd_pop = 1'b0;
        w_q_we    = 1'b0;
        w_s_we    = 1'b0;
        w_s_wdata = r_first;
        w_d_we    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_res     = '{symbol: 8'd0, status: ST_OK};
                    n_strobe  = 1'b1;
                    unique case (i_cmd.kind)
                        OP_START: begin
                            n_root  = w_new_root;
                            n_cw    = w_new_root + 1'b1;
                            n_limit = w_new_clear << 1;
                            n_free  = w_new_clear + CNT_W'(2);
                            n_sp    = '0;
                            n_head  = '0;
                            n_tail  = '0;
                            n_count = '0;
                            n_acc   = '0;
                            n_held  = '0;
                            n_sub   = '0;
                            n_term  = 1'b0;
                            n_first = '0;
                            n_prev  = '0;
                            n_phase = PH_FRESH;
                        end
                        OP_PUSH: begin
                            if (r_count == QC_W'(QUEUE_DEPTH)) begin
                                n_res.status = ST_OVF;
                            end else begin
                                w_q_we  = 1'b1;
                                n_tail  = (r_tail == QA_W'(QUEUE_DEPTH - 1)) ? '0
                                                                            : r_tail + 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_PULL: begin
                            priority if (r_phase == PH_END) begin
                                n_res.status = ST_END;
                            end else if (r_phase == PH_ERR) begin
                                n_res.status = ST_ERR;
                            end else if (r_sp != '0) begin
                                n_strobe = 1'b0;
                                n_sp     = r_sp - 1'b1;
                                n_state  = S_POP;
                            end else begin
                                n_strobe = 1'b0;
                                n_state  = S_FETCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FETCH: begin
                priority if (r_held >= HELD_W'(r_cw)) begin
                    n_code  = r_acc[CODE_W-1:0] & w_mask;
                    n_acc   = r_acc >> r_cw;
                    n_held  = r_held - HELD_W'(r_cw);
                    n_state = S_CODE;
                end else if (r_term) begin
                    n_phase  = PH_ERR;
                    n_res    = '{symbol: 8'd0, status: ST_ERR};
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_count == '0) begin
                    n_res    = '{symbol: 8'd0, status: ST_NEED};
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_head  = (r_head == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    n_count = r_count - 1'b1;
                    n_state = S_QRD;
                end
            end
            S_QRD: begin
                if (r_sub == '0) begin
                    if (w_q_rdata == '0) begin
                        n_term = 1'b1;
                    end else begin
                        n_sub = w_q_rdata;
                    end
                end else begin
                    n_acc  = r_acc | (ACC_W'(w_q_rdata) << r_held);
                    n_held = r_held + HELD_W'(8);
                    n_sub  = r_sub - 1'b1;
                end
                n_state = S_FETCH;
            end
            S_CODE: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
                n_res    = '{symbol: 8'd0, status: ST_ERR};
                priority if (w_code_x == w_clear) begin
                    n_strobe = 1'b0;
                    n_cw     = r_root + 1'b1;
                    n_limit  = w_clear << 1;
                    n_free   = w_clear + CNT_W'(2);
                    n_sp     = '0;
                    n_phase  = PH_FRESH;
                    n_state  = S_FETCH;
                end else if (w_code_x == w_clear + 1'b1) begin
                    n_phase      = PH_END;
                    n_res.status = ST_END;
                end else if (r_phase == PH_FRESH) begin
                    if (w_code_x > w_clear) begin
                        n_phase = PH_ERR;
                    end else begin
                        n_first = r_code[7:0];
                        n_prev  = r_code;
                        n_phase = PH_RUN;
                        n_res   = '{symbol: r_code[7:0], status: ST_SYM};
                    end
                end else if (w_code_x > r_free) begin
                    n_phase = PH_ERR;
                end else begin
                    n_strobe = 1'b0;
                    n_incode = r_code;
                    n_state  = S_WALK;
                    if (w_code_x == r_free) begin
                        w_s_we    = 1'b1;
                        w_s_wdata = r_first;
                        n_sp      = r_sp + 1'b1;
                        n_code    = r_prev;
                    end
                end
            end
            S_WALK: begin
                if (w_code_x >= w_clear) begin
                    n_state = S_WDAT;
                end else begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    if (r_sp == SP_W'(STACK_SIZE)) begin
                        n_phase = PH_ERR;
                        n_sp    = '0;
                        n_res   = '{symbol: 8'd0, status: ST_ERR};
                    end else begin
                        n_first = r_code[7:0];
                        n_res   = '{symbol: r_code[7:0], status: ST_SYM};
                        n_prev  = r_incode;
                        if (r_free < CNT_W'(TABLE_SIZE)) begin
                            w_d_we = 1'b1;
                            n_free = w_free_inc;
                            if (w_free_inc >= r_limit && r_limit < CNT_W'(TABLE_SIZE)) begin
                                n_limit = r_limit << 1;
                                n_cw    = r_cw + 1'b1;
                            end
                        end
                    end
                end
            end
            S_WDAT: begin
                if (r_sp == SP_W'(STACK_SIZE) || w_p_rdata == r_code) begin
                    n_phase  = PH_ERR;
                    n_sp     = '0;
                    n_res    = '{symbol: 8'd0, status: ST_ERR};
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    w_s_we    = 1'b1;
                    w_s_wdata = w_x_rdata;
                    n_sp      = r_sp + 1'b1;
                    n_code    = w_p_rdata;
                    n_state   = S_WALK;
                end
            end
            S_POP: begin
                n_res    = '{symbol: w_s_rdata, status: ST_SYM};
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_root   <= ROOT_W'(MAX_ROOT);
            r_cw     <= ROOT_W'(MAX_ROOT + 1);
            r_limit  <= CNT_W'(2 << MAX_ROOT);
            r_free   <= CNT_W'((1 << MAX_ROOT) + 2);
            r_first  <= '0;
            r_prev   <= '0;
            r_phase  <= PH_FRESH;
            r_acc    <= '0;
            r_held   <= '0;
            r_sub    <= '0;
            r_term   <= 1'b0;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_sp     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_root   <= n_root;
            r_cw     <= n_cw;
            r_limit  <= n_limit;
            r_free   <= n_free;
            r_first  <= n_first;
            r_prev   <= n_prev;
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_held   <= n_held;
            r_sub    <= n_sub;
            r_term   <= n_term;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_sp     <= n_sp;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code   <= n_code;
        r_incode <= n_incode;
        r_res    <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_SIZE))
        else $error("stack pointer beyond stack");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QC_W'(QUEUE_DEPTH))
        else $error("byte queue count beyond depth");
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held < HELD_W'(20))
        else $error("bit accumulator overfilled");
    a_sym_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_res.status == ST_SYM) |-> r_phase == PH_RUN)
        else $error("symbol delivered outside running phase");
    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE && i_cmd_valid))
        else $error("command taken while engine busy");

endmodule

@@ hw/rtl/gif_lzw_decoder.sv @@
// Top level of the GIF LZW decoder: command front end and decode engine.
// Depends on gld_pkg, gld_front, gld_back and gld_ram.
//
// Commands arrive on i_in and transfer when start is high and busy is low.
// Operation 0 starts an image (data_byte is the minimum code size, clamped
// to 2..8), 1 pushes one image-data stream byte including sub-block length
// bytes, 2 pulls one decoded pixel index, 3 does nothing.
// Every command gives exactly one result on o_result, held for one cycle
// and marked by o_strobe; results come in command order.
// A two-entry command queue sits in front of the engine, so busy rises only
// when two commands are waiting.
// Start, push and empty operations answer from S_IDLE, with the command
// registered in the command queue and the result in the output register.
// A pull that pops the symbol stack goes through S_POP; one that decodes a
// new code goes through S_FETCH and S_CODE, and S_WALK unless it is the
// first code after a start or clear, plus S_QRD per stream byte consumed,
// S_FETCH and S_CODE per clear code and S_WDAT per dictionary link walked.
// Reset behaves as a start with code size 8; no memory clearing pass runs.
// The receiver cannot stall: each result must be taken in its strobe cycle.
module gif_lzw_decoder import gld_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_in,
    output logic o_strobe,
    output t_out o_result
);

    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_pop;

    gld_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    gld_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule

@@ tb/gld_checker.sv @@
// Transfer monitor and result predictor for the GIF LZW decoder testbench.
// Depends on gld_pkg; watches the command and result channels of the decoder.
module gld_checker import gld_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_in  i_in,
    input  logic i_strobe,
    input  t_out i_result,
    output int   o_pending,
    output int   o_errors
);

    logic [11:0] prefix_mem [TABLE_SIZE];
    logic [7:0]  suffix_mem [TABLE_SIZE];
    logic [7:0]  sym_stack [STACK_SIZE];
    logic [7:0]  byte_fifo [QUEUE_DEPTH];
    int unsigned stk_ptr, fifo_head, fifo_count, acc, acc_bits, block_left;
    int unsigned width, roots, free_code, grow_at, first_sym, prev_code;
    bit          term_seen;
    t_phase      phase;
    t_out        expected_results[$];
    int          errors = 0;

    assign o_pending = expected_results.size();
    assign o_errors  = errors;

    function automatic void reset_dictionary();
        int unsigned clr;
        clr = 1 << roots;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            prefix_mem[i] = '0;
            suffix_mem[i] = (i < clr) ? 8'(i) : 8'd0;
        end
        width     = roots + 1;
        grow_at   = 2 * clr;
        free_code = clr + 2;
        stk_ptr   = 0;
    endfunction

    function automatic void begin_image(int unsigned min_size);
        if (min_size < MIN_ROOT) min_size = MIN_ROOT;
        if (min_size > MAX_ROOT) min_size = MAX_ROOT;
        roots = min_size;
        reset_dictionary();
        fifo_head  = 0;
        fifo_count = 0;
        acc        = 0;
        acc_bits   = 0;
        block_left = 0;
        term_seen  = 0;
        first_sym  = 0;
        prev_code  = 0;
        phase      = PH_FRESH;
    endfunction

    // 0 code read, 1 need data, 2 out of data
    function automatic int fetch_code(output int unsigned code);
        int unsigned b;
        code = 0;
        while (acc_bits < width && !term_seen && fifo_count > 0) begin
            b = byte_fifo[fifo_head];
            fifo_head = (fifo_head + 1) % QUEUE_DEPTH;
            fifo_count--;
            if (block_left == 0) begin
                if (b == 0) term_seen = 1;
                else block_left = b;
            end else begin
                acc |= b << acc_bits;
                acc_bits += 8;
                block_left--;
            end
        end
        if (acc_bits < width) return term_seen ? 2 : 1;
        code = acc & ((1 << width) - 1);
        acc = (acc >> width) & 32'hFFFFFF;
        acc_bits -= width;
        return 0;
    endfunction

    function automatic bit stack_push(int unsigned s);
        if (stk_ptr >= STACK_SIZE) return 0;
        sym_stack[stk_ptr] = 8'(s);
        stk_ptr++;
        return 1;
    endfunction

    function automatic t_status decode_symbol(output logic [7:0] sym);
        int unsigned clr, code, incode;
        int r;
        sym = 0;
        if (phase == PH_END) return ST_END;
        if (phase == PH_ERR) return ST_ERR;
        if (stk_ptr > 0) begin
            stk_ptr--;
            sym = sym_stack[stk_ptr];
            return ST_SYM;
        end
        clr = 1 << roots;
        forever begin
            r = fetch_code(code);
            if (r == 1) return ST_NEED;
            if (r == 2) begin
                phase = PH_ERR;
                return ST_ERR;
            end
            if (code == clr) begin
                reset_dictionary();
                phase = PH_FRESH;
                continue;
            end
            if (code == clr + 1) begin
                phase = PH_END;
                return ST_END;
            end
            if (phase == PH_FRESH) begin
                if (code > clr) begin
                    phase = PH_ERR;
                    return ST_ERR;
                end
                first_sym = code;
                prev_code = code;
                phase = PH_RUN;
                sym = 8'(code);
                return ST_SYM;
            end
            if (code > free_code) begin
                phase = PH_ERR;
                return ST_ERR;
            end
            incode = code;
            if (code == free_code) begin
                void'(stack_push(first_sym));
                code = prev_code;
            end
            while (code >= clr) begin
                if (!stack_push(suffix_mem[code % TABLE_SIZE]) ||
                    prefix_mem[code % TABLE_SIZE] == code) begin
                    phase = PH_ERR;
                    stk_ptr = 0;
                    return ST_ERR;
                end
                code = prefix_mem[code % TABLE_SIZE];
            end
            first_sym = suffix_mem[code];
            if (!stack_push(first_sym)) begin
                phase = PH_ERR;
                stk_ptr = 0;
                return ST_ERR;
            end
            if (free_code < TABLE_SIZE) begin
                prefix_mem[free_code] = 12'(prev_code);
                suffix_mem[free_code] = 8'(first_sym);
                free_code++;
                if (free_code >= grow_at && grow_at < TABLE_SIZE) begin
                    grow_at *= 2;
                    width++;
                end
            end
            prev_code = incode;
            stk_ptr--;
            sym = sym_stack[stk_ptr];
            return ST_SYM;
        end
    endfunction

    function automatic t_out predict_result(t_in item);
        t_out res;
        logic [7:0] sym;
        res.symbol = 0;
        res.status = ST_OK;
        case (t_op'(item.operation))
            OP_START: begin
                begin_image(item.data_byte);
            end
            OP_PUSH: begin
                if (fifo_count >= QUEUE_DEPTH) begin
                    res.status = ST_OVF;
                end else begin
                    byte_fifo[(fifo_head + fifo_count) % QUEUE_DEPTH] = item.data_byte;
                    fifo_count++;
                end
            end
            OP_PULL: begin
                res.status = decode_symbol(sym);
                if (res.status == ST_SYM) res.symbol = sym;
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic flag_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    initial begin
        begin_image(MAX_ROOT);
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (i_strobe) begin
                if (expected_results.size() == 0) begin
                    flag_mismatch("result with nothing outstanding");
                end else begin
                    want = expected_results.pop_front();
                    if (i_result.status !== want.status)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                i_result.status, want.status));
                    if (i_result.symbol !== want.symbol)
                        flag_mismatch($sformatf("symbol %0d, expected %0d",
                                                i_result.symbol, want.symbol));
                end
            end
            if (i_start && !i_busy)
                expected_results.push_back(predict_result(i_in));
        end
    end

endmodule

@@ tb/gif_lzw_decoder_tb.sv @@
// Top of the GIF LZW decoder testbench: clock, reset, command stimulus, verdict.
// Depends on gld_pkg, gif_lzw_decoder and gld_checker.
module gif_lzw_decoder_tb;
    import gld_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    logic busy;
    t_in  i_in = '0;
    logic o_strobe;
    t_out o_result;
    int   pending, errors;
    int   sent = 0;
    int   idle_pct = 0;
    int   cycles = 0;

    logic [7:0]  image_bytes[$];
    int unsigned pack_acc, pack_bits;

    gif_lzw_decoder uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_in(i_in), .o_strobe(o_strobe), .o_result(o_result)
    );

    gld_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_in(i_in), .i_strobe(o_strobe), .i_result(o_result),
        .o_pending(pending), .o_errors(errors)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic issue(t_op op, logic [7:0] d);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        start <= 1;
        i_in  <= '{operation: op, data_byte: d};
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        sent++;
        idle_pct = (((sent / 100) % 4) == 1) ? 73 :
                   (((sent / 100) % 4) == 3) ? 27 : 0;
    endtask

    task automatic pack_code(int unsigned code, int unsigned w);
        pack_acc |= code << pack_bits;
        pack_bits += w;
        while (pack_bits >= 8) begin
            image_bytes.push_back(pack_acc[7:0]);
            pack_acc >>= 8;
            pack_bits -= 8;
        end
    endtask

    // build a sub-blocked code stream; mostly legal, sometimes broken
    task automatic build_image(int unsigned roots, int unsigned ncodes, bit with_end);
        int unsigned clr, w, free_code, grow_at, c;
        bit fresh;
        logic [7:0] raw[$];
        int unsigned len, blk;
        clr = 1 << roots;
        w = roots + 1; free_code = clr + 2; grow_at = 2 * clr; fresh = 1;
        image_bytes = {}; pack_acc = 0; pack_bits = 0;
        if ($urandom_range(1)) pack_code(clr, w);
        repeat (ncodes) begin
            if ($urandom_range(99) < 5) begin
                pack_code(clr, w);
                w = roots + 1; free_code = clr + 2; grow_at = 2 * clr; fresh = 1;
            end else if (fresh) begin
                pack_code($urandom_range(clr - 1), w);
                fresh = 0;
            end else begin
                c = $urandom_range(free_code);
                if (c == clr || c == clr + 1) c = $urandom_range(clr - 1);
                pack_code(c, w);
                if (free_code < TABLE_SIZE) begin
                    free_code++;
                    if (free_code >= grow_at && grow_at < TABLE_SIZE) begin
                        grow_at *= 2;
                        w++;
                    end
                end
            end
        end
        if (with_end) pack_code(clr + 1, w);
        if (pack_bits > 0) image_bytes.push_back(pack_acc[7:0]);
        if ($urandom_range(19) == 0) image_bytes[$urandom_range(image_bytes.size() - 1)]
            = 8'($urandom);
        raw = image_bytes;
        image_bytes = {};
        while (raw.size() > 0) begin
            blk = ($urandom_range(9) == 0) ? 255 : $urandom_range(1, 20);
            len = (raw.size() < blk) ? raw.size() : blk;
            image_bytes.push_back(8'(len));
            repeat (len) image_bytes.push_back(raw.pop_front());
        end
        image_bytes.push_back(8'd0);
    endtask

    initial begin
        int unsigned roots, ncodes, pulls;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        issue(OP_START, 8'hFF);
        issue(OP_NOP, 8'hA5);
        issue(OP_PULL, 8'h00);
        issue(OP_PUSH, 8'h00);
        issue(OP_PULL, 8'h00);
        issue(OP_PULL, 8'h00);
        issue(OP_START, 8'h00);
        issue(OP_PUSH, 8'h01);
        issue(OP_PUSH, 8'h07);
        issue(OP_PULL, 8'h00);
        issue(OP_START, 8'h01);
        issue(OP_PUSH, 8'h02);
        issue(OP_PUSH, 8'hCC);
        issue(OP_PUSH, 8'h01);
        issue(OP_PULL, 8'h00);
        issue(OP_PULL, 8'h00);
        issue(OP_PUSH, 8'hFF);
        issue(OP_START, 8'h09);
        issue(OP_PULL, 8'h00);

        while (sent < 900) begin
            if ($urandom_range(15) == 0) roots = $urandom_range(255);
            else roots = $urandom_range(MIN_ROOT, MAX_ROOT);
            issue(OP_START, 8'(roots));
            if (roots < MIN_ROOT) roots = MIN_ROOT;
            if (roots > MAX_ROOT) roots = MAX_ROOT;
            if ($urandom_range(11) == 0) begin
                repeat ($urandom_range(3, 12)) issue(t_op'($urandom_range(3)), 8'($urandom));
                continue;
            end
            if (sent > 500 && sent < 520) begin
                repeat (QUEUE_DEPTH + 3) issue(OP_PUSH, 8'($urandom));
                issue(OP_PULL, 8'h00);
                continue;
            end
            ncodes = $urandom_range(4, 40);
            build_image(roots, ncodes, $urandom_range(9) != 0);
            pulls = ncodes * 3 + 4;
            while (image_bytes.size() > 0 || pulls > 0) begin
                repeat ($urandom_range(1, 8))
                    if (image_bytes.size() > 0) issue(OP_PUSH, image_bytes.pop_front());
                repeat ($urandom_range(1, 6))
                    if (pulls > 0) begin
                        issue(OP_PULL, 8'($urandom));
                        pulls--;
                    end
            end
        end
        start <= 0;
        @(posedge i_clk);
        while (pending > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
